>>> rtl/bdfr_pkg.sv
package bdfr_pkg;

    localparam int BINARY_BYTES = 4;
    localparam int BIN_CNT_W    = $clog2(BINARY_BYTES + 1);

    localparam logic [7:0] START_SYMBOL_RESET = 8'h24;
    localparam logic [7:0] CH_CR              = 8'h0D;
    localparam logic [7:0] CH_LF              = 8'h0A;

    localparam int HELD_DEPTH = 3;
    localparam int HELD_CNT_W = 2;

    localparam int TEXT_LEN_W = 16;
    localparam int WORD_W     = 32;
    localparam int TDATA_W    = 56;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_START_SYMBOL = '0;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_END    = 2'd1,
        KIND_BINARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [7:0]            text_byte;
        logic [TEXT_LEN_W-1:0] text_length;
        logic [WORD_W-1:0]     binary_word;
    } result_t;

endpackage

>>> rtl/bdfr_core.sv
module bdfr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        start_symbol,
    output bdfr_pkg::result_t result
);

    logic                                bin_active_reg, bin_active_next;
    logic [bdfr_pkg::BIN_CNT_W-1:0]      bin_count_reg, bin_count_next;
    logic [bdfr_pkg::WORD_W-9:0]         bin_bytes_reg, bin_bytes_next;
    logic [7:0]                          held_reg [bdfr_pkg::HELD_DEPTH];
    logic [7:0]                          held_next [bdfr_pkg::HELD_DEPTH];
    logic [bdfr_pkg::HELD_CNT_W-1:0]     held_count_reg, held_count_next;
    logic [bdfr_pkg::TEXT_LEN_W-1:0]     text_count_reg, text_count_next;
    logic [bdfr_pkg::BIN_CNT_W-1:0]      bin_count_inc;
    logic                                terminator;

    assign bin_count_inc = bin_count_reg + 1'b1;
    assign terminator = (held_reg[0] == bdfr_pkg::CH_CR) && (held_reg[1] == bdfr_pkg::CH_LF)
                     && (held_reg[2] == bdfr_pkg::CH_CR) && (data_byte == bdfr_pkg::CH_LF);

    always_comb begin
        bin_active_next = bin_active_reg;
        bin_count_next  = bin_count_reg;
        bin_bytes_next  = bin_bytes_reg;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        text_count_next = text_count_reg;
        result          = '0;
        result.kind     = bdfr_pkg::KIND_TEXT;

        if (accept) begin
            if (data_byte == start_symbol) begin
                bin_active_next = 1'b1;
                bin_count_next  = '0;
                bin_bytes_next  = '0;
            end else if (bin_active_reg) begin
                if (bin_count_inc >= bdfr_pkg::BIN_CNT_W'(bdfr_pkg::BINARY_BYTES)) begin
                    result.valid       = 1'b1;
                    result.kind        = bdfr_pkg::KIND_BINARY;
                    result.binary_word = {bin_bytes_reg, data_byte};
                    bin_active_next    = 1'b0;
                    bin_count_next     = '0;
                    bin_bytes_next     = '0;
                end else begin
                    bin_count_next = bin_count_inc;
                    bin_bytes_next = {bin_bytes_reg[bdfr_pkg::WORD_W-17:0], data_byte};
                end
            end else if (held_count_reg < bdfr_pkg::HELD_CNT_W'(bdfr_pkg::HELD_DEPTH)) begin
                held_next[held_count_reg] = data_byte;
                held_count_next           = held_count_reg + 1'b1;
            end else if (terminator) begin
                result.valid       = 1'b1;
                result.kind        = bdfr_pkg::KIND_END;
                result.text_length = text_count_reg;
                held_count_next    = '0;
                text_count_next    = '0;
            end else begin
                result.valid     = 1'b1;
                result.kind      = bdfr_pkg::KIND_TEXT;
                result.text_byte = held_reg[0];
                held_next[0]     = held_reg[1];
                held_next[1]     = held_reg[2];
                held_next[2]     = data_byte;
                if (text_count_reg != '1) begin
                    text_count_next = text_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (!aresetn) begin
            bin_active_reg <= 1'b0;
            bin_count_reg  <= '0;
            bin_bytes_reg  <= '0;
            held_count_reg <= '0;
            text_count_reg <= '0;
        end else begin
            bin_active_reg <= bin_active_next;
            bin_count_reg  <= bin_count_next;
            bin_bytes_reg  <= bin_bytes_next;
            held_count_reg <= held_count_next;
            text_count_reg <= text_count_next;
        end
    end

endmodule

>>> rtl/bdfr_out_reg.sv
module bdfr_out_reg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bdfr_pkg::result_t                result,
    output logic                             in_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bdfr_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser
);

    logic                          valid_reg, valid_next;
    bdfr_pkg::result_t             data_reg, data_next;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = result.valid;
            data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.binary_word, data_reg.text_length, data_reg.text_byte};
    assign m_tuser  = data_reg.kind;

endmodule

>>> rtl/binary_and_text_packet_deframer.sv
// Channel  Dir  Signals                         Contents
// s_       in   s_tvalid s_tready s_tdata[7:0]  data_byte
// m_       out  m_tvalid m_tready m_tdata[55:0] text_byte, text_length, binary_word
//                           m_tuser[1:0]        kind
// apb      in   psel penable pwrite paddr[2:0]  start_symbol at address 0
//
// One item per cycle while s_tready is high; a result appears on m_ in the cycle after its item is taken.
// The single output register sets latency; s_tready drops only while a result waits.
// Reset (aresetn low, synchronous) clears packet state; start_symbol returns to 0x24.
// Held text bytes are not cleared by reset.
module binary_and_text_packet_deframer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bdfr_pkg::TDATA_W-1:0] m_tdata,   // [7:0] text_byte, [23:8] text_length,
                                                    // [55:24] binary_word
    output logic [1:0]                   m_tuser,   // [1:0] kind
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [7:0]        start_symbol_reg;
    logic              sel_start;
    logic              accept;
    bdfr_pkg::result_t result;

    assign pready    = 1'b1;
    assign sel_start = (paddr[bdfr_pkg::PADDR_W-1:2] == bdfr_pkg::REG_START_SYMBOL);
    assign prdata    = sel_start ? {24'd0, start_symbol_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_symbol_reg <= bdfr_pkg::START_SYMBOL_RESET;
        end else if (psel && penable && pwrite && pready && sel_start) begin
            start_symbol_reg <= pwdata[7:0];
        end
    end

    assign accept = s_tvalid && s_tready;

    bdfr_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_tdata),
        .start_symbol (start_symbol_reg),
        .result       (result)
    );

    bdfr_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> bench/tb.sv
module tb;

    localparam int LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 130;
    localparam logic [bdfr_pkg::PADDR_W-1:0] START_ADDR = {bdfr_pkg::REG_START_SYMBOL, 2'b00};

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_QUIET,
        ROW_RESULT
    } row_how_t;

    typedef struct packed {
        logic [7:0]      b;
        row_how_t        how;
        bdfr_pkg::kind_t kind;
        logic [31:0]     v;
    } dir_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bdfr_pkg::TDATA_W-1:0]  m_tdata;
    logic [1:0]                    m_tuser;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bdfr_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    binary_and_text_packet_deframer dut (.*);

    // predictor state
    logic [7:0]  sym_start;
    bit          bin_open;
    int          bin_got;
    logic [31:0] bin_acc;
    logic [7:0]  held [bdfr_pkg::HELD_DEPTH];
    int          held_n;
    logic [15:0] text_n;

    bdfr_pkg::result_t queued_results [$];
    row_how_t          row_how;
    bdfr_pkg::result_t row_exp;
    bit                src_idle;
    bit                sink_idle;
    int                errors;
    int                cycles;
    int                n_sent;
    dir_row_t          dir_tab [24];

    function automatic bit deframe_step(input logic [7:0] b, output bdfr_pkg::result_t r);
        r = '0;
        r.valid = 1'b1;
        if (b == sym_start) begin
            bin_open = 1'b1;
            bin_got = 0;
            bin_acc = '0;
            return 1'b0;
        end
        if (bin_open) begin
            bin_acc = {bin_acc[23:0], b};
            bin_got++;
            if (bin_got >= bdfr_pkg::BINARY_BYTES) begin
                r.kind = bdfr_pkg::KIND_BINARY;
                r.binary_word = bin_acc;
                bin_open = 1'b0;
                bin_got = 0;
                bin_acc = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (held_n < bdfr_pkg::HELD_DEPTH) begin
            held[held_n] = b;
            held_n++;
            return 1'b0;
        end
        if (held[0] == bdfr_pkg::CH_CR && held[1] == bdfr_pkg::CH_LF
                && held[2] == bdfr_pkg::CH_CR && b == bdfr_pkg::CH_LF) begin
            r.kind = bdfr_pkg::KIND_END;
            r.text_length = text_n;
            held_n = 0;
            text_n = '0;
            return 1'b1;
        end
        r.kind = bdfr_pkg::KIND_TEXT;
        r.text_byte = held[0];
        held[0] = held[1];
        held[1] = held[2];
        held[2] = b;
        if (text_n != 16'hFFFF)
            text_n++;
        return 1'b1;
    endfunction

    function automatic bdfr_pkg::result_t typed_result(input bdfr_pkg::kind_t k,
                                                       input logic [31:0] v);
        bdfr_pkg::result_t r;
        r = '0;
        r.valid = 1'b1;
        r.kind = k;
        case (k)
            bdfr_pkg::KIND_TEXT: r.text_byte = v[7:0];
            bdfr_pkg::KIND_END:  r.text_length = v[15:0];
            default:             r.binary_word = v;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 9))
            0:       return bdfr_pkg::CH_CR;
            1:       return bdfr_pkg::CH_LF;
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s: expected %h actual %h", $time, what, want, got);
        end
    endtask

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin : monitor
        bdfr_pkg::result_t want;
        bdfr_pkg::result_t nxt;
        bit                fresh;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (queued_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected item: expected none actual kind %h",
                             $time, m_tuser);
                end else begin
                    want = queued_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_tuser));
                    check_field("text_byte", 32'(want.text_byte), 32'(m_tdata[7:0]));
                    check_field("text_length", 32'(want.text_length), 32'(m_tdata[23:8]));
                    check_field("binary_word", want.binary_word, m_tdata[55:24]);
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = deframe_step(s_tdata, nxt);
                if (row_how == ROW_RESULT)
                    queued_results.push_back(row_exp);
                else if (row_how == ROW_MODEL && fresh)
                    queued_results.push_back(nxt);
            end
        end
    end

    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (sink_idle && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic push_row(input logic [7:0] b, input row_how_t how,
                            input bdfr_pkg::result_t exp);
        @(negedge aclk);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        row_how = how;
        row_exp = exp;
        n_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send(input logic [7:0] b);
        push_row(b, ROW_MODEL, '0);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (queued_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_start_symbol(input logic [7:0] v);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = START_ADDR;
        pwdata = {24'b0, v};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sym_start = v;
        @(negedge aclk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("start_symbol", {24'b0, v}, prdata);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_terminator();
        send(bdfr_pkg::CH_CR);
        send(bdfr_pkg::CH_LF);
        send(bdfr_pkg::CH_CR);
        send(bdfr_pkg::CH_LF);
    endtask

    task automatic random_phase(input int target, input bit idle_ok);
        while (n_sent < target) begin
            src_idle = idle_ok && ($urandom_range(0, 3) != 0);
            sink_idle = idle_ok && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(0, 10)) send(pick_text());
                    if ($urandom_range(0, 4) != 0)
                        send_terminator();
                end
                4, 5, 6: begin
                    send(sym_start);
                    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                         : bdfr_pkg::BINARY_BYTES)
                        send(8'($urandom_range(0, 255)));
                end
                7: begin
                    send(bdfr_pkg::CH_CR);
                    send(bdfr_pkg::CH_LF);
                    send(bdfr_pkg::CH_CR);
                    send(pick_text());
                end
                8: repeat ($urandom_range(1, 5)) send(8'($urandom_range(0, 255)));
                default: begin
                    send(bdfr_pkg::CH_CR);
                    send(bdfr_pkg::CH_LF);
                    send(sym_start);
                    repeat (bdfr_pkg::BINARY_BYTES) send(8'($urandom_range(0, 255)));
                    send(bdfr_pkg::CH_CR);
                    send(bdfr_pkg::CH_LF);
                end
            endcase
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        row_how = ROW_MODEL;
        row_exp = '0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        errors = 0;
        cycles = 0;
        n_sent = 0;
        sym_start = bdfr_pkg::START_SYMBOL_RESET;
        bin_open = 1'b0;
        bin_got = 0;
        bin_acc = '0;
        held_n = 0;
        text_n = '0;

        dir_tab = '{
            {8'h24, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h00, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h24, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},   // restart mid-packet
            {8'hFF, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h80, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h01, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h7F, ROW_RESULT, bdfr_pkg::KIND_BINARY, 32'hFF80017F},
            {8'h0D, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},   // bare terminator
            {8'h0A, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h0D, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h0A, ROW_RESULT, bdfr_pkg::KIND_END,    32'h0},
            {8'h41, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h42, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h43, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h44, ROW_RESULT, bdfr_pkg::KIND_TEXT,   32'h41},
            {8'h24, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},   // binary inside text
            {8'h00, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h55, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'hAA, ROW_QUIET,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'hFF, ROW_RESULT, bdfr_pkg::KIND_BINARY, 32'h0055AAFF},
            {8'h0D, ROW_MODEL,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h0A, ROW_MODEL,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h0D, ROW_MODEL,  bdfr_pkg::KIND_TEXT,   32'h0},
            {8'h0A, ROW_RESULT, bdfr_pkg::KIND_END,    32'h4}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i])
            push_row(dir_tab[i].b, dir_tab[i].how,
                     typed_result(dir_tab[i].kind, dir_tab[i].v));

        random_phase(PHASE_ITEMS, 1'b1);
        set_start_symbol(8'h00);
        random_phase(2 * PHASE_ITEMS, 1'b1);
        set_start_symbol(8'hFF);
        random_phase(3 * PHASE_ITEMS, 1'b1);
        set_start_symbol(bdfr_pkg::CH_CR);
        random_phase(4 * PHASE_ITEMS, 1'b1);
        set_start_symbol(8'($urandom_range(0, 255)));

        // last part runs without idling
        random_phase(5 * PHASE_ITEMS, 1'b0);

        drain();
        repeat (5) @(posedge aclk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
